/* hdl/ablh_pkg.sv */
`timescale 1ns / 1ps

package ablh_pkg;

  // address space and block geometry
  localparam int unsigned BLOCK_SHIFT = 20;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned BLK_W       = ADDR_BITS - BLOCK_SHIFT;
  localparam logic [63:0] NUM_BLOCKS  = 64'(1) << BLK_W;

  // field widths
  localparam int unsigned OP_W    = 1;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ATYPE_W = 2;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned BIN_W   = 12;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TOT_W   = 48;

  // end address of a span needs one carry bit
  localparam int unsigned SPAN_W = ADDR_W + 1;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned IN_TUSER_W  = OP_W + KIND_W + ATYPE_W;
  localparam int unsigned OUT_TDATA_W = CNT_W + 2 * TOT_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_RECORD = 1'b0;
  localparam logic [OP_W-1:0] OP_READ   = 1'b1;

  // entry kinds
  localparam logic [KIND_W-1:0] KIND_INSTR0 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSTR1 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INSTR2 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MEM0   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MEM1   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_MEM2   = 3'd6;

  // access types
  localparam logic [ATYPE_W-1:0] ATYPE_LOAD = 2'd0;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WR0,
    ST_RD1,
    ST_WR1,
    ST_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic tot_upd;
    logic mem_rd;
    logic mem_wr;
    logic sel_second;
    logic clr_wr;
    logic out_load;
  } ablh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic bump0;
    logic bump1;
    logic clr_last;
  } ablh_stat_t;

endpackage

/* hdl/ablh_dpath.sv */
`timescale 1ns / 1ps

module ablh_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ablh_pkg::ablh_cmd_t          cmd_i,
  output ablh_pkg::ablh_stat_t         stat_o,
  input  logic [ablh_pkg::OP_W-1:0]    operation_i,
  input  logic [ablh_pkg::KIND_W-1:0]  entry_kind_i,
  input  logic [ablh_pkg::ATYPE_W-1:0] access_type_i,
  input  logic [ablh_pkg::ADDR_W-1:0]  address_i,
  input  logic [ablh_pkg::SIZE_W-1:0]  access_size_i,
  input  logic [ablh_pkg::BIN_W-1:0]   bin_index_i,
  output logic [ablh_pkg::CNT_W-1:0]   bin_count_o,
  output logic [ablh_pkg::TOT_W-1:0]   instruction_total_o,
  output logic [ablh_pkg::TOT_W-1:0]   memory_access_total_o
);
  import ablh_pkg::*;

  // block counter store, single port
  logic [CNT_W-1:0] mem [NUM_BLOCKS];

  logic [CNT_W-1:0] rdata_q;
  logic [BLK_W-1:0] clr_idx_q, clr_idx_d;

  // latched item
  logic             is_read_q, is_instr_q, is_mem_q, bump0_q, bump1_q, bin_ok_q;
  logic [BLK_W-1:0] idx0_q, idx1_q, bin_q;

  logic [TOT_W-1:0] instr_q, instr_d, memtot_q, memtot_d;
  logic [CNT_W-1:0] bin_count_q;
  logic [TOT_W-1:0] instr_out_q, mem_out_q;

  // decode of the incoming item
  logic              in_is_instr, in_is_mem, in_is_lmem;
  logic [SIZE_W-1:0] span;
  logic [SPAN_W-1:0] end_addr, first_blk, last_blk;
  logic              first_ok, last_ok, in_bin_ok;

  always_comb begin
    in_is_instr = 1'b0;
    in_is_mem   = 1'b0;
    in_is_lmem  = 1'b0;
    unique case (entry_kind_i) inside
      KIND_INSTR0, KIND_INSTR1, KIND_INSTR2: begin
        in_is_instr = 1'b1;
      end
      KIND_MEM0, KIND_MEM1: begin
        in_is_mem  = 1'b1;
        in_is_lmem = (access_type_i == ATYPE_LOAD);
      end
      KIND_MEM2: begin
        in_is_mem = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // byte span to first and last block, zero size treated as one byte
  always_comb begin
    span      = (access_size_i == '0) ? SIZE_W'(1) : access_size_i;
    end_addr  = SPAN_W'(address_i) + SPAN_W'(span) - SPAN_W'(1);
    first_blk = SPAN_W'(address_i) >> BLOCK_SHIFT;
    last_blk  = end_addr >> BLOCK_SHIFT;
    first_ok  = 64'(first_blk) < NUM_BLOCKS;
    last_ok   = 64'(last_blk) < NUM_BLOCKS;
    in_bin_ok = 64'(bin_index_i) < NUM_BLOCKS;
  end

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      is_read_q  <= (operation_i == OP_READ);
      is_instr_q <= (operation_i == OP_RECORD) && in_is_instr;
      is_mem_q   <= (operation_i == OP_RECORD) && in_is_mem;
      bump0_q    <= (operation_i == OP_RECORD) && in_is_lmem && first_ok;
      bump1_q    <= (operation_i == OP_RECORD) && in_is_lmem && last_ok &&
                    (last_blk != first_blk);
      idx0_q     <= BLK_W'(first_blk);
      idx1_q     <= BLK_W'(last_blk);
      bin_q      <= BLK_W'(bin_index_i);
      bin_ok_q   <= in_bin_ok;
    end
  end

  // clearing sweep index
  always_comb begin
    clr_idx_d = cmd_i.clr_wr ? clr_idx_q + BLK_W'(1) : clr_idx_q;
  end

  // saturating totals
  always_comb begin
    instr_d  = instr_q;
    memtot_d = memtot_q;
    if (cmd_i.tot_upd) begin
      if (is_instr_q && (instr_q != '1)) instr_d = instr_q + TOT_W'(1);
      if (is_mem_q && (memtot_q != '1)) memtot_d = memtot_q + TOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      instr_q   <= '0;
      memtot_q  <= '0;
    end else begin
      clr_idx_q <= clr_idx_d;
      instr_q   <= instr_d;
      memtot_q  <= memtot_d;
    end
  end

  // store address and write data
  logic [BLK_W-1:0] mem_addr;
  logic [CNT_W-1:0] mem_wdata;
  logic             mem_we;

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_addr = clr_idx_q;
    end else if (is_read_q) begin
      mem_addr = bin_q;
    end else begin
      mem_addr = cmd_i.sel_second ? idx1_q : idx0_q;
    end
    if (cmd_i.clr_wr) begin
      mem_wdata = '0;
    end else begin
      mem_wdata = (rdata_q == '1) ? rdata_q : rdata_q + CNT_W'(1);
    end
    mem_we = cmd_i.clr_wr || cmd_i.mem_wr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_count_q <= (is_read_q && bin_ok_q) ? rdata_q : '0;
      instr_out_q <= instr_q;
      mem_out_q   <= memtot_q;
    end
  end

  assign bin_count_o           = bin_count_q;
  assign instruction_total_o   = instr_out_q;
  assign memory_access_total_o = mem_out_q;

  assign stat_o.is_read  = is_read_q;
  assign stat_o.bump0    = bump0_q;
  assign stat_o.bump1    = bump1_q;
  assign stat_o.clr_last = (clr_idx_q == '1);

endmodule

/* hdl/ablh_ctrl.sv */
`timescale 1ns / 1ps

module ablh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ablh_pkg::ablh_stat_t  stat_i,
  output ablh_pkg::ablh_cmd_t   cmd_o
);
  import ablh_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat_i.is_read) begin
          state_d = ST_DONE;
        end else if (stat_i.bump0) begin
          state_d = ST_WR0;
        end else if (stat_i.bump1) begin
          state_d = ST_WR1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WR0: begin
        state_d = stat_i.bump1 ? ST_RD1 : ST_DONE;
      end
      ST_RD1: begin
        state_d = ST_WR1;
      end
      ST_WR1: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.tot_upd = 1'b1;
        if (stat_i.is_read || stat_i.bump0) begin
          cmd_o.mem_rd = 1'b1;
        end else if (stat_i.bump1) begin
          cmd_o.mem_rd     = 1'b1;
          cmd_o.sel_second = 1'b1;
        end
      end
      ST_WR0: begin
        cmd_o.mem_wr = 1'b1;
      end
      ST_RD1: begin
        cmd_o.mem_rd     = 1'b1;
        cmd_o.sel_second = 1'b1;
      end
      ST_WR1: begin
        cmd_o.mem_wr     = 1'b1;
        cmd_o.sel_second = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_rd && (cmd_o.mem_wr || cmd_o.clr_wr)))
    else $error("store read and write in the same cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> $past(cmd_o.mem_rd))
    else $error("counter written without a read the cycle before");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("item accepted during clearing sweep");

endmodule

/* hdl/address_block_load_heatmap.sv */
`timescale 1ns / 1ps

// Load heat map by 1 MiB address block. Each input transfer is either a
// profile record or a read of one block counter, and gives exactly one
// result transfer carrying the block count (zero for records) and the
// instruction and memory-access totals after the item. All counters
// saturate. After reset the 4096-entry counter store is swept to zero, one
// entry per cycle, so no input is taken until the sweep is done. The store
// is a single-port memory with a registered read, and each block bump is a
// read then a write on that port: a load crossing a block boundary bumps
// both blocks in turn, and each item runs to its result before the next is
// taken. A finished result waits in an output register, and the next item
// is taken while it waits.
module address_block_load_heatmap (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // address, access_size, bin_index, zero padding
  input  logic [ablh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation, entry_kind, access_type
  input  logic [ablh_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // bin_count, instruction_total, memory_access_total
  output logic [ablh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import ablh_pkg::*;

  ablh_cmd_t  cmd;
  ablh_stat_t stat;

  logic [CNT_W-1:0] bin_count;
  logic [TOT_W-1:0] instruction_total;
  logic [TOT_W-1:0] memory_access_total;

  ablh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ablh_dpath u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .operation_i           (s_axis_tuser[OP_W-1:0]),
    .entry_kind_i          (s_axis_tuser[OP_W+KIND_W-1:OP_W]),
    .access_type_i         (s_axis_tuser[OP_W+KIND_W+ATYPE_W-1:OP_W+KIND_W]),
    .address_i             (s_axis_tdata[ADDR_W-1:0]),
    .access_size_i         (s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
    .bin_index_i           (s_axis_tdata[ADDR_W+SIZE_W+BIN_W-1:ADDR_W+SIZE_W]),
    .bin_count_o           (bin_count),
    .instruction_total_o   (instruction_total),
    .memory_access_total_o (memory_access_total)
  );

  // result packing, first field lowest
  assign m_axis_tdata = {memory_access_total, instruction_total, bin_count};

endmodule

/* tb/address_block_load_heatmap_tb.sv */
`timescale 1ns / 1ps

module address_block_load_heatmap_tb;
  import ablh_pkg::*;

  localparam int unsigned CLK_HALF    = 4;
  localparam int unsigned RANDOM_RECS = 1950;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 16;

  // codes with no name in the package
  localparam logic [KIND_W-1:0]  KIND_OTHER      = 3'd0;
  localparam logic [KIND_W-1:0]  KIND_OTHER_HI   = 3'd7;
  localparam logic [ATYPE_W-1:0] ATYPE_STORE     = 2'd1;
  localparam logic [ATYPE_W-1:0] ATYPE_OTHER_MEM = 2'd2;
  localparam logic [ATYPE_W-1:0] ATYPE_UNUSED    = 2'd3;

  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KIND_W-1:0]  kind;
    logic [ATYPE_W-1:0] atype;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
    logic [BIN_W-1:0]   bin;
  } profile_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] bin_count;
    logic [TOT_W-1:0] instr_total;
    logic [TOT_W-1:0] mem_total;
  } heat_report_t;

  // mirror of the block's counters and the reports it owes
  class heatmap_scoreboard;
    logic [CNT_W-1:0] blk_count [2**BLK_W];
    logic [TOT_W-1:0] instr_total;
    logic [TOT_W-1:0] mem_total;
    heat_report_t     pending_reports [$];
    int unsigned      errors;

    function void clear_counts();
      foreach (blk_count[i]) blk_count[i] = '0;
      instr_total = '0;
      mem_total   = '0;
      errors      = 0;
    endfunction

    function void bump_block(logic [SPAN_W-1:0] blk);
      if (blk < NUM_BLOCKS && blk_count[blk[BLK_W-1:0]] != COUNT_MAX)
        blk_count[blk[BLK_W-1:0]]++;
    endfunction

    // update the mirror for one accepted item and queue its report
    function void note_item(profile_item_t it);
      heat_report_t      rep;
      logic [SPAN_W-1:0] span_end;
      logic [SPAN_W-1:0] first_blk;
      logic [SPAN_W-1:0] last_blk;
      logic [SIZE_W-1:0] span;
      rep.bin_count = '0;
      if (it.op == OP_READ) begin
        if (it.bin < NUM_BLOCKS) rep.bin_count = blk_count[it.bin];
      end else begin
        if (it.kind inside {KIND_INSTR0, KIND_INSTR1, KIND_INSTR2} && instr_total != TOTAL_MAX)
          instr_total++;
        if (it.kind inside {KIND_MEM0, KIND_MEM1, KIND_MEM2} && mem_total != TOTAL_MAX)
          mem_total++;
        if ((it.kind == KIND_MEM0 || it.kind == KIND_MEM1) && it.atype == ATYPE_LOAD) begin
          span      = (it.size == '0) ? SIZE_W'(1) : it.size;
          span_end  = SPAN_W'(it.addr) + SPAN_W'(span) - SPAN_W'(1);
          first_blk = SPAN_W'(it.addr) >> BLOCK_SHIFT;
          last_blk  = span_end >> BLOCK_SHIFT;
          bump_block(first_blk);
          if (last_blk != first_blk) bump_block(last_blk);
        end
      end
      rep.instr_total = instr_total;
      rep.mem_total   = mem_total;
      pending_reports.push_back(rep);
    endfunction

    // compare one result transfer with the oldest report owed
    function void check_report(logic [OUT_TDATA_W-1:0] data);
      heat_report_t exp_rep;
      logic [CNT_W-1:0] got_count;
      logic [TOT_W-1:0] got_instr;
      logic [TOT_W-1:0] got_mem;
      got_count = data[CNT_W-1:0];
      got_instr = data[CNT_W +: TOT_W];
      got_mem   = data[CNT_W+TOT_W +: TOT_W];
      if (pending_reports.size() == 0) begin
        $error("unexpected result: bin_count %0d instruction_total %0d memory_access_total %0d",
               got_count, got_instr, got_mem);
        errors++;
        return;
      end
      exp_rep = pending_reports.pop_front();
      if (got_count !== exp_rep.bin_count) begin
        $error("bin_count: expected %0d, got %0d", exp_rep.bin_count, got_count);
        errors++;
      end
      if (got_instr !== exp_rep.instr_total) begin
        $error("instruction_total: expected %0d, got %0d", exp_rep.instr_total, got_instr);
        errors++;
      end
      if (got_mem !== exp_rep.mem_total) begin
        $error("memory_access_total: expected %0d, got %0d", exp_rep.mem_total, got_mem);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // address, access_size, bin_index, zero padding
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // operation, entry_kind, access_type
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // bin_count, instruction_total, memory_access_total
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  heatmap_scoreboard sb;
  logic              no_gaps;
  int unsigned       cycle_count;
  logic [BLK_W-1:0]  hot_blk [8];

  address_block_load_heatmap u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  // one transfer on the input side, after a random gap
  task automatic send_item(input profile_item_t it);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - ADDR_W - SIZE_W - BIN_W){1'b0}}, it.bin, it.size, it.addr};
    s_axis_tuser  <= {it.atype, it.kind, it.op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  function automatic profile_item_t make_item(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind,
                                              logic [ATYPE_W-1:0] atype, logic [ADDR_W-1:0] addr,
                                              logic [SIZE_W-1:0] size, logic [BIN_W-1:0] bin);
    profile_item_t it;
    it.op    = op;
    it.kind  = kind;
    it.atype = atype;
    it.addr  = addr;
    it.size  = size;
    it.bin   = bin;
    return it;
  endfunction

  // many loads; addresses mostly in a few busy blocks, often close to a boundary
  function automatic profile_item_t random_item();
    profile_item_t it;
    logic [BLOCK_SHIFT-1:0] offset;
    it.op    = ($urandom_range(0, 9) < 3) ? OP_READ : OP_RECORD;
    it.kind  = ($urandom_range(0, 1) == 0) ? KIND_W'($urandom_range(4, 5))
                                          : KIND_W'($urandom_range(0, 7));
    it.atype = ($urandom_range(0, 9) < 7) ? ATYPE_LOAD : ATYPE_W'($urandom_range(0, 3));
    offset   = ($urandom_range(0, 2) == 0) ? BLOCK_SHIFT'(2**BLOCK_SHIFT - 1 - $urandom_range(0, 300))
                                           : BLOCK_SHIFT'($urandom);
    it.addr  = ($urandom_range(0, 9) < 6) ? {hot_blk[$urandom_range(0, 7)], offset}
                                          : ADDR_W'($urandom);
    case ($urandom_range(0, 19))
      0:       it.size = '0;
      1, 2, 3: it.size = SIZE_W'($urandom);
      default: it.size = SIZE_W'($urandom_range(1, 512));
    endcase
    it.bin   = ($urandom_range(0, 9) < 7) ? hot_blk[$urandom_range(0, 7)] : BIN_W'($urandom);
    return it;
  endfunction

  // result side: random stalls, check every transfer
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_report(m_axis_tdata);
    end
  end

  // reset, directed items, random items, drain
  initial begin
    sb = new;
    sb.clear_counts();
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hot_blk[0] = '0;
    hot_blk[1] = '1;
    hot_blk[2] = BLK_W'(1);
    for (int i = 3; i < 8; i++) hot_blk[i] = BLK_W'($urandom);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store, totals, unused kinds
    send_item(make_item(OP_READ, KIND_OTHER, ATYPE_LOAD, '0, '0, '0));
    send_item(make_item(OP_RECORD, KIND_INSTR0, ATYPE_LOAD, '0, 16'd1, '0));
    send_item(make_item(OP_RECORD, KIND_INSTR1, ATYPE_STORE, '1, 16'd4, '1));
    send_item(make_item(OP_RECORD, KIND_INSTR2, ATYPE_UNUSED, 32'h0000_0100, 16'd8, '0));
    send_item(make_item(OP_RECORD, KIND_OTHER, ATYPE_LOAD, 32'h0000_0010, 16'd4, '0));
    send_item(make_item(OP_RECORD, KIND_OTHER_HI, ATYPE_LOAD, 32'h0000_0020, 16'd4, '0));
    // loads in one block, across a boundary, size zero
    send_item(make_item(OP_RECORD, KIND_MEM0, ATYPE_LOAD, '0, 16'd1, '0));
    send_item(make_item(OP_RECORD, KIND_MEM1, ATYPE_LOAD, 32'h000F_FFFF, 16'd2, '0));
    send_item(make_item(OP_RECORD, KIND_MEM0, ATYPE_LOAD, 32'h001F_FFFF, 16'd0, '0));
    // memory kind 2 and non-load access types leave the blocks alone
    send_item(make_item(OP_RECORD, KIND_MEM2, ATYPE_LOAD, '0, 16'd4, '0));
    send_item(make_item(OP_RECORD, KIND_MEM0, ATYPE_STORE, '0, 16'd4, '0));
    send_item(make_item(OP_RECORD, KIND_MEM1, ATYPE_OTHER_MEM, '0, 16'd4, '0));
    send_item(make_item(OP_RECORD, KIND_MEM0, ATYPE_UNUSED, '0, 16'd4, '0));
    // span running off the top of the address space, the last byte, and other maximum-size spans
    send_item(make_item(OP_RECORD, KIND_MEM1, ATYPE_LOAD, 32'hFFFF_FFF0, '1, '0));
    send_item(make_item(OP_RECORD, KIND_MEM0, ATYPE_LOAD, '1, 16'd1, '1));
    send_item(make_item(OP_RECORD, KIND_MEM0, ATYPE_LOAD, 32'h1234_5678, '1, '1));
    send_item(make_item(OP_RECORD, KIND_MEM1, ATYPE_LOAD, 32'h123F_0001, '1, '0));
    // read back touched blocks and some untouched ones
    send_item(make_item(OP_READ, KIND_OTHER, ATYPE_LOAD, '0, '0, 12'd0));
    send_item(make_item(OP_READ, KIND_OTHER, ATYPE_LOAD, '0, '0, 12'd1));
    send_item(make_item(OP_READ, KIND_OTHER, ATYPE_LOAD, '0, '0, 12'd2));
    send_item(make_item(OP_READ, KIND_MEM0, ATYPE_STORE, '0, '0, 12'h123));
    send_item(make_item(OP_READ, KIND_OTHER, ATYPE_LOAD, '0, '0, 12'h124));
    send_item(make_item(OP_READ, KIND_OTHER_HI, ATYPE_UNUSED, '1, '1, '1));

    // random part, with stretches of back-to-back traffic
    for (int n = 0; n < RANDOM_RECS; n++) begin
      if (n % 128 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
